// ===== hw/rtl/espi_pkg.sv =====
package espi_pkg;

   // input commands
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_ZERO  = 2'd1;
   localparam logic [1:0] CMD_REPLY = 2'd2;

   // result actions
   localparam logic [1:0] ACT_SEND      = 2'd0;
   localparam logic [1:0] ACT_READ_DONE = 2'd1;
   localparam logic [1:0] ACT_ZERO_DONE = 2'd2;
   localparam logic [1:0] ACT_REJECT    = 2'd3;

   // error codes
   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_LINK   = 2'd1;
   localparam logic [1:0] ERR_PARITY = 2'd2;
   localparam logic [1:0] ERR_SENSOR = 2'd3;

   // sensor register addresses and frame bits
   localparam logic [14:0] ADDR_ANGLE = 15'h3FFF;
   localparam logic [14:0] ADDR_ZHIGH = 15'h0016;
   localparam logic [14:0] ADDR_ZLOW  = 15'h0017;
   localparam logic [14:0] READ_BIT   = 15'h4000;
   localparam int unsigned ERR_FLAG_BIT = 14;
   localparam logic [22:0] DEG_SCALE  = 23'd360;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_RD1   = 7'b0000010,
      PH_RD2   = 7'b0000100,
      PH_ZHADR = 7'b0001000,
      PH_ZHDAT = 7'b0010000,
      PH_ZLADR = 7'b0100000,
      PH_ZLDAT = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] zero_position;
      logic [15:0] rx_frame;
      logic        link_fail;
   } item_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] tx_frame;
      logic [13:0] angle_reading;
      logic [22:0] angle_scaled;
      logic [1:0]  error_code;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic        operation;
      logic [13:0] zero_target;
      logic [1:0]  kept_low_bits;
      logic        error_latch;
      logic [22:0] angle_degrees;
   } state_type;

   // bit 15 makes the whole frame even parity
   function automatic logic [15:0] with_parity(input logic [14:0] v);
      return {^v, v};
   endfunction

endpackage

// ===== hw/rtl/espi_step.sv =====
module espi_step (
   input  espi_pkg::item_type   item,
   input  espi_pkg::state_type  st,
   output espi_pkg::state_type  st_nxt,
   output espi_pkg::result_type res
);

   logic        latch;
   logic [1:0]  code;
   logic [13:0] data;

   always_comb begin
      latch = st.error_latch | item.link_fail;
      if (latch) begin
         code = espi_pkg::ERR_LINK;
      end else if (^item.rx_frame) begin
         code = espi_pkg::ERR_PARITY;
      end else if (item.rx_frame[espi_pkg::ERR_FLAG_BIT]) begin
         code = espi_pkg::ERR_SENSOR;
      end else begin
         code = espi_pkg::ERR_OK;
      end
      data = (code == espi_pkg::ERR_OK) ? item.rx_frame[13:0] : 14'd0;
   end

   always_comb begin
      st_nxt = st;
      res.action        = espi_pkg::ACT_REJECT;
      res.tx_frame      = 16'd0;
      res.angle_reading = 14'd0;
      res.error_code    = espi_pkg::ERR_OK;
      case (item.command)
         espi_pkg::CMD_READ, espi_pkg::CMD_ZERO: begin
            if (st.phase == espi_pkg::PH_IDLE) begin
               st_nxt.operation   = item.command[0];
               st_nxt.error_latch = 1'b0;
               st_nxt.zero_target = item.zero_position;
               st_nxt.phase       = espi_pkg::PH_RD1;
               res.action         = espi_pkg::ACT_SEND;
               res.tx_frame       = espi_pkg::with_parity(espi_pkg::READ_BIT |
                  ((item.command == espi_pkg::CMD_READ) ? espi_pkg::ADDR_ANGLE
                                                       : espi_pkg::ADDR_ZLOW));
            end
         end
         espi_pkg::CMD_REPLY: begin
            case (st.phase)
               espi_pkg::PH_IDLE: begin
                  res.action = espi_pkg::ACT_REJECT;
               end
               espi_pkg::PH_RD1: begin
                  st_nxt.error_latch = latch;
                  st_nxt.phase       = espi_pkg::PH_RD2;
                  res.action         = espi_pkg::ACT_SEND;
                  res.tx_frame       = espi_pkg::with_parity(espi_pkg::READ_BIT);
               end
               espi_pkg::PH_RD2: begin
                  if (!st.operation) begin
                     st_nxt.error_latch = latch;
                     st_nxt.phase       = espi_pkg::PH_IDLE;
                     if (code == espi_pkg::ERR_OK) begin
                        st_nxt.angle_degrees = 23'(data) * espi_pkg::DEG_SCALE;
                     end
                     res.action        = espi_pkg::ACT_READ_DONE;
                     res.angle_reading = data;
                     res.error_code    = code;
                  end else begin
                     st_nxt.kept_low_bits = data[7:6];
                     st_nxt.error_latch   = 1'b0;
                     st_nxt.phase         = espi_pkg::PH_ZHADR;
                     res.action           = espi_pkg::ACT_SEND;
                     res.tx_frame         = espi_pkg::with_parity(espi_pkg::ADDR_ZHIGH);
                  end
               end
               espi_pkg::PH_ZHADR: begin
                  st_nxt.phase = espi_pkg::PH_ZHDAT;
                  res.action   = espi_pkg::ACT_SEND;
                  res.tx_frame = espi_pkg::with_parity({7'd0, st.zero_target[13:6]});
               end
               espi_pkg::PH_ZHDAT: begin
                  st_nxt.error_latch = 1'b0;
                  st_nxt.phase       = espi_pkg::PH_ZLADR;
                  res.action         = espi_pkg::ACT_SEND;
                  res.tx_frame       = espi_pkg::with_parity(espi_pkg::ADDR_ZLOW);
               end
               espi_pkg::PH_ZLADR: begin
                  st_nxt.error_latch = latch;
                  st_nxt.phase       = espi_pkg::PH_ZLDAT;
                  res.action         = espi_pkg::ACT_SEND;
                  res.tx_frame       = espi_pkg::with_parity(
                     {7'd0, st.kept_low_bits, st.zero_target[5:0]});
               end
               espi_pkg::PH_ZLDAT: begin
                  st_nxt.error_latch = latch;
                  st_nxt.phase       = espi_pkg::PH_IDLE;
                  res.action         = espi_pkg::ACT_ZERO_DONE;
                  res.error_code     = {1'b0, latch};
               end
               default: begin
                  st_nxt.phase = espi_pkg::PH_IDLE;
               end
            endcase
         end
         default: begin
            res.action = espi_pkg::ACT_REJECT;
         end
      endcase
      res.angle_scaled = st_nxt.angle_degrees;
   end

endmodule

// ===== hw/rtl/encoder_spi_frame_sequencer.sv =====
// a word accepted on req is held in the input register, then moves to the result register
// and is offered on rsp from there; a stall on rsp can hold it in either register
// throughput: one word per cycle; req_ready drops only while both registers hold words
// that rsp has not yet taken
// reset (synchronous, active high) empties both registers, returns the sequence to idle and
// clears the zero target, kept bits, error latch and last good angle
module encoder_spi_frame_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [13:0] req_zero_position,
   input  logic [15:0] req_rx_frame,
   input  logic        req_link_fail,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [15:0] rsp_tx_frame,
   output logic [13:0] rsp_angle_reading,
   output logic [22:0] rsp_angle_scaled,
   output logic [1:0]  rsp_error_code
);

   // input register
   logic                 item_valid_ff;
   logic                 item_valid_in;
   espi_pkg::item_type   item_ff;
   espi_pkg::item_type   item_in;

   // sequencer state, updated when a word moves to the result register
   espi_pkg::state_type  state_ff;
   espi_pkg::state_type  state_in;

   // result register
   logic                 res_valid_ff;
   logic                 res_valid_in;
   espi_pkg::result_type res_ff;
   espi_pkg::result_type res_in;

   logic                 advance;
   logic                 req_fire;

   // the word in the input register moves on when the result register is free
   // or being emptied in this same cycle
   assign advance   = item_valid_ff & (~res_valid_ff | rsp_ready);
   assign req_ready = ~item_valid_ff | advance;
   assign req_fire  = req_valid & req_ready;

   assign item_in.command       = req_command;
   assign item_in.zero_position = req_zero_position;
   assign item_in.rx_frame      = req_rx_frame;
   assign item_in.link_fail     = req_link_fail;

   // one pass of frame building, reply checking and angle scaling
   espi_pkg::state_type  st_nxt;
   espi_pkg::result_type step_res;

   espi_step u_step (
      .item   (item_ff),
      .st     (state_ff),
      .st_nxt (st_nxt),
      .res    (step_res)
   );

   always_comb begin
      item_valid_in = req_fire | (item_valid_ff & ~advance);
      state_in      = advance ? st_nxt : state_ff;
      res_in        = advance ? step_res : res_ff;
      res_valid_in  = advance | (res_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff          <= 1'b0;
         res_valid_ff           <= 1'b0;
         state_ff.phase         <= espi_pkg::PH_IDLE;
         state_ff.operation     <= 1'b0;
         state_ff.zero_target   <= 14'd0;
         state_ff.kept_low_bits <= 2'd0;
         state_ff.error_latch   <= 1'b0;
         state_ff.angle_degrees <= 23'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         res_valid_ff  <= res_valid_in;
         state_ff      <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid         = res_valid_ff;
   assign rsp_action        = res_ff.action;
   assign rsp_tx_frame      = res_ff.tx_frame;
   assign rsp_angle_reading = res_ff.angle_reading;
   assign rsp_angle_scaled  = res_ff.angle_scaled;
   assign rsp_error_code    = res_ff.error_code;

endmodule

// ===== hw/rtl/espi_checker.sv =====
module espi_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_action,
   input  logic [15:0] rsp_tx_frame,
   input  logic [13:0] rsp_angle_reading,
   input  logic [1:0]  rsp_error_code
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_frame) && $stable(rsp_action))
      else $error("rsp word changed while stalled");

   // every frame sent has even parity
   a_even_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == espi_pkg::ACT_SEND |-> !(^rsp_tx_frame))
      else $error("tx frame has odd parity");

   // no frame outside a send
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != espi_pkg::ACT_SEND |-> rsp_tx_frame == 16'd0)
      else $error("tx frame set outside send");

   // a failed read reports no angle
   a_raw_on_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != espi_pkg::ERR_OK |-> rsp_angle_reading == 14'd0)
      else $error("raw angle on failed read");

   // only done words carry an error code
   a_code_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == espi_pkg::ACT_SEND || rsp_action == espi_pkg::ACT_REJECT)
      |-> rsp_error_code == espi_pkg::ERR_OK)
      else $error("error code outside done");

endmodule

bind encoder_spi_frame_sequencer espi_checker u_espi_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_action        (rsp_action),
   .rsp_tx_frame      (rsp_tx_frame),
   .rsp_angle_reading (rsp_angle_reading),
   .rsp_error_code    (rsp_error_code)
);
